>>> rtl/bdo_pkg.sv
// ---------------------------------------------------------------------------
// bdo_pkg: shared types and constants of the business day offset block
// Status codes, side-band payload, calendar tables and reciprocal constants
// used for the fixed divisions of the date conversion.
// ---------------------------------------------------------------------------
`default_nettype none

package bdo_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DATE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	// fields that ride along the pipeline to the end; status is set on a bad date or range error
	typedef struct packed {
		logic [16:0] secs;
		status_t     status;
	} side_t;

	// days in a 400-year era
	localparam int unsigned ERA_DAYS = 146097;

	// day numbers counted from 0000-03-01
	localparam logic signed [35:0] LO_ZZ = 36'sd306;
	localparam logic signed [35:0] HI_ZZ = 36'sd3652364;

	// reciprocals: floor(x / D) = (x * M) >> S, with S = width(x) + width(D) unless given
	localparam logic [10:0] M_Y400   = 11'd1311;   // (y >> 4) / 25, S = 15
	localparam logic [22:0] M_ERA    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [18:0] M_1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] M_36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] M_146096 = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
	localparam logic [18:0] M_365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [11:0] M_153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
	localparam logic [11:0] M_5S     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
	localparam logic [31:0] M_DIV5   = 32'hCCCC_CCCD;  // S = 34

	// first day of the month within a March-based year
	function automatic logic [8:0] doy_base(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	// x mod 7 by folding octal digits (8 is 1 mod 7)
	function automatic logic [2:0] mod7(input logic [18:0] x);
		logic [5:0] s1;
		logic [3:0] s2;
		logic [2:0] s3;
		s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
			+ 6'(x[17:15]) + 6'(x[18]);
		s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
		s3 = s2[2:0] + 3'(s2[3]);
		return (s3 == 3'd7) ? 3'd0 : s3;
	endfunction

endpackage

`default_nettype wire

>>> rtl/bdo_req_if.sv
// ---------------------------------------------------------------------------
// bdo_req_if: request channel of the business day offset block
// Start date, offset, mode flag and time of day with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface bdo_req_if #(
	parameter int OFFSET_BITS = 17
);
	logic                          valid;
	logic                          ready;
	logic [13:0]                   start_year;
	logic [3:0]                    start_month;
	logic [4:0]                    start_day;
	logic signed [OFFSET_BITS-1:0] day_offset;
	logic                          weekdays_only;
	logic [16:0]                   start_seconds;

	modport source(output valid, start_year, start_month, start_day, day_offset,
		weekdays_only, start_seconds, input ready);
	modport sink(input valid, start_year, start_month, start_day, day_offset,
		weekdays_only, start_seconds, output ready);
endinterface

`default_nettype wire

>>> rtl/bdo_rsp_if.sv
// ---------------------------------------------------------------------------
// bdo_rsp_if: result channel of the business day offset block
// Result date, copied time of day and status with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface bdo_rsp_if;
	logic        valid;
	logic        ready;
	logic [13:0] result_year;
	logic [3:0]  result_month;
	logic [4:0]  result_day;
	logic [16:0] result_seconds;
	logic [1:0]  status;

	modport source(output valid, result_year, result_month, result_day,
		result_seconds, status, input ready);
	modport sink(input valid, result_year, result_month, result_day,
		result_seconds, status, output ready);
endinterface

`default_nettype wire

>>> rtl/bdo_to_civil.sv
// ---------------------------------------------------------------------------
// bdo_to_civil: day number to year, month and day
// Eight register stages; every fixed division is a reciprocal multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module bdo_to_civil (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid,
	input  wire logic [21:0]    zz,
	input  wire bdo_pkg::side_t side,
	output logic                out_valid,
	output logic [13:0]         year,
	output logic [3:0]          month,
	output logic [4:0]          day,
	output bdo_pkg::side_t      out_side
);

	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	bdo_pkg::side_t side_s8, side_s9, side_s10, side_s11, side_s12, side_s13, side_s14;
	logic [4:0]  era_s8, era_s9, era_s10, era_s11, era_s12, era_s13, era_s14;
	logic [21:0] zz_s8;
	logic [17:0] doe_s9, doe_s10, doe_s11, doe_s12, num_s11;
	logic [7:0]  a_s10;
	logic [2:0]  b_s10;
	logic        c_s10;
	logic [8:0]  yoe_s12, yoe_s13, yoe_s14;
	logic [8:0]  doy_s13, doy_s14;
	logic [3:0]  mp_s14;
	logic [13:0] year_s15;
	logic [3:0]  month_s15;
	logic [4:0]  day_s15;
	bdo_pkg::side_t side_s15;

	logic [44:0] pera_c;
	logic [21:0] doe_c;
	logic [36:0] pa_c, pb_c, pc_c, py_c;
	logic [17:0] sub_c;
	logic [13:0] p41_c;
	logic [10:0] x153_c, x5_c;
	logic [22:0] pm_c, pd_c;
	logic [3:0]  mm_c;
	logic [13:0] y_c;

	// advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15} <= '0;
		end else if (en) begin
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15} <=
				{valid, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14};
		end
	end

	// era of the day number
	assign pera_c = 45'(zz) * 45'(bdo_pkg::M_ERA);
	// day of era
	assign doe_c = zz_s8 - 22'(era_s8) * 22'(bdo_pkg::ERA_DAYS);
	// leap corrections
	assign pa_c = 37'(doe_s9) * 37'(bdo_pkg::M_1460);
	assign pb_c = 37'(doe_s9) * 37'(bdo_pkg::M_36524);
	assign pc_c = 37'(doe_s9) * 37'(bdo_pkg::M_146096);
	// year of era
	assign py_c = 37'(num_s11) * 37'(bdo_pkg::M_365);
	// day of year
	assign p41_c = 14'(yoe_s12) * 14'd41;
	assign sub_c = 18'(yoe_s12) * 18'd365 + 18'(yoe_s12[8:2]) - 18'(p41_c[13:12]);
	// March-based month
	assign x153_c = 11'(doy_s13) * 11'd5 + 11'd2;
	assign pm_c   = 23'(x153_c) * 23'(bdo_pkg::M_153);
	// day of month and civil year
	assign x5_c = 11'(mp_s14) * 11'd153 + 11'd2;
	assign pd_c = 23'(x5_c) * 23'(bdo_pkg::M_5S);
	assign mm_c = (mp_s14 < 4'd10) ? mp_s14 + 4'd3 : mp_s14 - 4'd9;
	assign y_c  = 14'(yoe_s14) + 14'(era_s14) * 14'd400 + 14'(mm_c <= 4'd2);

	always_ff @(posedge clk) begin
		if (en) begin
			era_s8  <= pera_c[44:40];
			zz_s8   <= zz;
			side_s8 <= side;

			doe_s9  <= doe_c[17:0];
			era_s9  <= era_s8;
			side_s9 <= side_s8;

			doe_s10  <= doe_s9;
			a_s10    <= pa_c[36:29];
			b_s10    <= pb_c[36:34];
			c_s10    <= pc_c[36];
			era_s10  <= era_s9;
			side_s10 <= side_s9;

			num_s11  <= doe_s10 - 18'(a_s10) + 18'(b_s10) - 18'(c_s10);
			doe_s11  <= doe_s10;
			era_s11  <= era_s10;
			side_s11 <= side_s10;

			yoe_s12  <= py_c[35:27];
			doe_s12  <= doe_s11;
			era_s12  <= era_s11;
			side_s12 <= side_s11;

			doy_s13  <= 9'(doe_s12 - sub_c);
			yoe_s13  <= yoe_s12;
			era_s13  <= era_s12;
			side_s13 <= side_s12;

			mp_s14   <= pm_c[22:19];
			doy_s14  <= doy_s13;
			yoe_s14  <= yoe_s13;
			era_s14  <= era_s13;
			side_s14 <= side_s13;

			// zero the date on any error
			side_s15 <= side_s14;
			if (side_s14.status == bdo_pkg::ST_OK) begin
				year_s15  <= y_c;
				month_s15 <= mm_c;
				day_s15   <= 5'(doy_s14 - pd_c[22:14] + 9'd1);
			end else begin
				year_s15  <= '0;
				month_s15 <= '0;
				day_s15   <= '0;
			end
		end
	end

	assign out_valid = v_s15;
	assign year      = year_s15;
	assign month     = month_s15;
	assign day       = day_s15;
	assign out_side  = side_s15;

endmodule

`default_nettype wire

>>> rtl/business_day_offset.sv
// ---------------------------------------------------------------------------
// business_day_offset: move a Gregorian date by a signed number of days
// Calendar or weekday stepping, input date check and result range check.
// ---------------------------------------------------------------------------
//  channel  dir  contents
//  req      in   start date, day_offset, weekdays_only, start_seconds
//  rsp      out  result date, result_seconds, status
//
//  One transaction per cycle while no result is held at rsp.
//  Fifteen register stages: date to day number (3), offset and weekday step
//  (4, with one 32x32 reciprocal multiply), day number to date (8).
//  A result held at rsp stalls the whole pipeline; req.ready follows.
//  Reset clears the valid bits only.
// ---------------------------------------------------------------------------
`default_nettype none

module business_day_offset #(
	parameter int OFFSET_BITS = 17
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bdo_req_if.sink   req,
	bdo_rsp_if.source rsp
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	bdo_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	logic [13:0] y_s1, yy_s1;
	logic [3:0]  m_s1;
	logic [4:0]  d_s1;
	logic [5:0]  era_s1, ey_s1;
	logic signed [32:0] n_s1, n_s2, n_s3;
	logic wk_s1, wk_s2, wk_s3, bad_s1;
	logic [17:0] doe_s2;
	logic [5:0]  era_s2;
	logic [22:0] zz_s3;
	logic [2:0]  w_s3;
	logic signed [35:0] b_s4, b_s5, zp_s4, zp_s5, res_s6;
	logic [31:0] t_s4, t_s5;
	logic neg_s4, neg_s5, wkm_s4, wkm_s5;
	logic [29:0] q_s5;
	logic [21:0] zz_s7;

	logic [13:0] yy_c;
	logic [20:0] pe_c, py_c;
	logic [13:0] e400_c, y400_c;
	logic [8:0]  yoe_c, r400_c, doy_c;
	logic leap_c, bad_c;
	logic [14:0] p41_c;
	logic [17:0] doe_c;
	logic [2:0]  w_c;
	logic [32:0] mag_c;
	logic [31:0] t_c;
	logic signed [35:0] b_c, zz36_c;
	logic [63:0] p5_c;
	logic [33:0] delta_c;
	logic oor_c;
	logic [35:0] dlt36_c;
	bdo_pkg::side_t side_c, side7_c;
	bdo_pkg::side_t side_out;
	logic v_out;

	// stall everything while a result waits
	assign en        = !v_out || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{req.valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	// stage 1: March-based year, eras of both years
	assign yy_c = (req.start_month <= 4'd2) ? req.start_year - 14'd1 : req.start_year;
	assign pe_c = 21'(yy_c[13:4]) * 21'(bdo_pkg::M_Y400);
	assign py_c = 21'(req.start_year[13:4]) * 21'(bdo_pkg::M_Y400);
	assign side_c.secs   = req.start_seconds;
	assign side_c.status = bdo_pkg::ST_OK;

	// stage 2: leap year, date check, day of era
	assign e400_c = 14'(era_s1) * 14'd400;
	assign y400_c = 14'(ey_s1) * 14'd400;
	assign yoe_c  = 9'(yy_s1 - e400_c);
	assign r400_c = 9'(y_s1 - y400_c);
	assign leap_c = (r400_c[1:0] == 2'd0) && (r400_c != 9'd100) && (r400_c != 9'd200)
		&& (r400_c != 9'd300);
	assign bad_c  = bad_s1 || (d_s1 > bdo_pkg::month_len(m_s1, leap_c));
	assign doy_c  = bdo_pkg::doy_base(m_s1) + 9'(d_s1) - 9'd1;
	assign p41_c  = 15'(yoe_c) * 15'd41;
	assign doe_c  = 18'(yoe_c) * 18'd365 + 18'(yoe_c[8:2]) - 18'(p41_c[14:12]) + 18'(doy_c);

	// stage 4: weekday step set-up
	assign mag_c  = n_s3[32] ? -n_s3 : n_s3;
	assign zz36_c = $signed({13'd0, zz_s3});
	always_comb begin
		if (!n_s3[32]) begin
			t_c = 32'((w_s3 < 3'd4) ? w_s3 : 3'd4) + mag_c[31:0];
			b_c = zz36_c - 36'(w_s3);
		end else if (w_s3 > 3'd4) begin
			t_c = 32'd4 + mag_c[31:0];
			b_c = zz36_c - 36'(w_s3) + 36'sd11;
		end else begin
			t_c = 32'(3'd4 - w_s3) + mag_c[31:0];
			b_c = zz36_c - 36'(w_s3) + 36'sd4;
		end
	end

	// stage 5: t / 5
	assign p5_c = t_s4 * bdo_pkg::M_DIV5;

	// stage 6: t + 2 * (t / 5) days either way
	assign delta_c = {2'd0, t_s5} + {3'd0, q_s5, 1'b0};
	assign dlt36_c = 36'(delta_c);

	// stage 7: range check
	assign oor_c = (res_s6 < bdo_pkg::LO_ZZ) || (res_s6 > bdo_pkg::HI_ZZ);
	always_comb begin
		side7_c = side_s6;
		if (side_s6.status == bdo_pkg::ST_OK && oor_c) begin
			side7_c.status = bdo_pkg::ST_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1    <= req.start_year;
			yy_s1   <= yy_c;
			m_s1    <= req.start_month;
			d_s1    <= req.start_day;
			era_s1  <= pe_c[20:15];
			ey_s1   <= py_c[20:15];
			n_s1    <= {{(33-OFFSET_BITS){req.day_offset[OFFSET_BITS-1]}}, req.day_offset};
			wk_s1   <= req.weekdays_only;
			bad_s1  <= (req.start_year == 14'd0) || (req.start_year > 14'd9999)
				|| (req.start_month == 4'd0) || (req.start_month > 4'd12)
				|| (req.start_day == 5'd0);
			side_s1 <= side_c;

			doe_s2  <= doe_c;
			era_s2  <= era_s1;
			n_s2    <= n_s1;
			wk_s2   <= wk_s1;
			side_s2.secs   <= side_s1.secs;
			side_s2.status <= bad_c ? bdo_pkg::ST_BAD_DATE : side_s1.status;

			zz_s3   <= 23'(era_s2) * 23'(bdo_pkg::ERA_DAYS) + 23'(doe_s2);
			w_s3    <= w_c;
			n_s3    <= n_s2;
			wk_s3   <= wk_s2;
			side_s3 <= side_s2;

			b_s4    <= b_c;
			t_s4    <= t_c;
			neg_s4  <= n_s3[32];
			wkm_s4  <= wk_s3 && (n_s3 != 33'sd0);
			zp_s4   <= zz36_c + {{3{n_s3[32]}}, n_s3};
			side_s4 <= side_s3;

			q_s5    <= p5_c[63:34];
			t_s5    <= t_s4;
			b_s5    <= b_s4;
			neg_s5  <= neg_s4;
			wkm_s5  <= wkm_s4;
			zp_s5   <= zp_s4;
			side_s5 <= side_s4;

			if (!wkm_s5) begin
				res_s6 <= zp_s5;
			end else if (neg_s5) begin
				res_s6 <= b_s5 - $signed(dlt36_c);
			end else begin
				res_s6 <= b_s5 + $signed(dlt36_c);
			end
			side_s6 <= side_s5;

			zz_s7   <= res_s6[21:0];
			side_s7 <= side7_c;
		end
	end

	// weekday of the day number (day of era + 2, mod 7; Monday is 0)
	assign w_c = bdo_pkg::mod7(19'(doe_s2) + 19'd2);

	bdo_to_civil u_to_civil (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (v_s7),
		.zz        (zz_s7),
		.side      (side_s7),
		.out_valid (v_out),
		.year      (rsp.result_year),
		.month     (rsp.result_month),
		.day       (rsp.result_day),
		.out_side  (side_out)
	);

	assign rsp.valid          = v_out;
	assign rsp.result_seconds = side_out.secs;
	assign rsp.status         = side_out.status;

endmodule

`default_nettype wire

>>> rtl/bdo_checker.sv
// ---------------------------------------------------------------------------
// bdo_checker: port-level checks of the business day offset block
// Watches both channels and the result fields; attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module bdo_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [13:0] rsp_year,
	input wire logic [3:0]  rsp_month,
	input wire logic [4:0]  rsp_day,
	input wire logic [1:0]  rsp_status
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year) && $stable(rsp_status))
		else $error("result changed while stalled");

	// accept whenever the output stage is empty
	a_req_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty output");

	// drop the date on any error
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != bdo_pkg::ST_OK |->
		rsp_year == 14'd0 && rsp_month == 4'd0 && rsp_day == 5'd0)
		else $error("date not cleared on error");

	// a good result is a real date
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bdo_pkg::ST_OK |->
		rsp_year != 14'd0 && rsp_year <= 14'd9999 && rsp_month != 4'd0
		&& rsp_month <= 4'd12 && rsp_day != 5'd0)
		else $error("result date out of range");

endmodule

bind business_day_offset bdo_checker u_bdo_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_year   (rsp.result_year),
	.rsp_month  (rsp.result_month),
	.rsp_day    (rsp.result_day),
	.rsp_status (rsp.status)
);

`default_nettype wire

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for business_day_offset
// Drives date queries through the request channel with random gaps, predicts
// each result from a day-number calendar model and checks every transaction
// on the result channel in order, including a long receiver hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OFFSET_BITS = 17;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic [13:0]      year;
		logic [3:0]       month;
		logic [4:0]       day;
		logic [16:0]      secs;
		bdo_pkg::status_t status;
	} date_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bdo_req_if #(.OFFSET_BITS(OFFSET_BITS)) req();
	bdo_rsp_if rsp();

	business_day_offset #(.OFFSET_BITS(OFFSET_BITS)) u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	date_result_t expected_dates[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_off_cycles = 0;
	bit sink_stall_rand = 1'b1;

	always #4 clk = ~clk;

	// calendar model on linear day numbers, day 0 is 1970-01-01
	function automatic longint to_day_num(longint y, longint m, longint d);
		longint yy, era, yoe, doy, doe;
		yy = (m <= 2) ? y - 1 : y;
		era = yy / 400;
		yoe = yy - era * 400;
		doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic void from_day_num(longint z, output longint y, output longint m,
		output longint d);
		longint zz, era, doe, yoe, doy, mp;
		zz = z + 719468;
		era = zz / 146097;
		doe = zz - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		m = (mp < 10) ? mp + 3 : mp - 9;
		d = doy - (153 * mp + 2) / 5 + 1;
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic longint step_weekdays(longint z, longint n);
		longint w, base, wb, total, k;
		w = (z + 3) % 7;
		if (w < 0) w += 7;
		if (n > 0) begin
			base = (w > 4) ? z - (w - 4) : z;
			wb = (w > 4) ? 4 : w;
			total = wb + n;
			return base - wb + (total / 5) * 7 + (total % 5);
		end
		base = (w > 4) ? z + (7 - w) : z;
		wb = (w > 4) ? 0 : w;
		k = (4 - wb) - n;
		return base + (4 - wb) - (k / 5) * 7 - (k % 5);
	endfunction

	function automatic date_result_t predict_date(logic [13:0] y, logic [3:0] m,
		logic [4:0] d, logic signed [OFFSET_BITS-1:0] offs, logic wk, logic [16:0] secs);
		date_result_t r;
		longint len, z, ry, rm, rd, n;
		bit leap;
		r.year = '0; r.month = '0; r.day = '0; r.secs = secs; r.status = bdo_pkg::ST_OK;
		n = offs;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) begin
			r.status = bdo_pkg::ST_BAD_DATE;
		end else begin
			case (m)
				2: len = leap ? 29 : 28;
				4, 6, 9, 11: len = 30;
				default: len = 31;
			endcase
			if (d > len) r.status = bdo_pkg::ST_BAD_DATE;
		end
		if (r.status == bdo_pkg::ST_OK) begin
			z = to_day_num(y, m, d);
			if (n != 0) z = wk ? step_weekdays(z, n) : z + n;
			if (z < to_day_num(1, 1, 1) || z > to_day_num(9999, 12, 31)) begin
				r.status = bdo_pkg::ST_RANGE;
			end else begin
				from_day_num(z, ry, rm, rd);
				r.year = 14'(ry); r.month = 4'(rm); r.day = 5'(rd);
			end
		end
		return r;
	endfunction

	// send one transaction after a random gap and queue its prediction
	task automatic send_query(logic [13:0] y, logic [3:0] m, logic [4:0] d,
		logic signed [OFFSET_BITS-1:0] offs, logic wk, logic [16:0] secs, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0) gap = 0;
		// drop valid over the gap only
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.start_year <= y; req.start_month <= m; req.start_day <= d;
		req.day_offset <= offs; req.weekdays_only <= wk; req.start_seconds <= secs;
		expected_dates.insert(expected_dates.size(), predict_date(y, m, d, offs, wk, secs));
		do @(posedge clk); while (!req.ready);
	endtask

	function automatic logic [4:0] days_in(logic [13:0] y, logic [3:0] m);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			2: return leap ? 5'd29 : 5'd28;
			4, 6, 9, 11: return 5'd30;
			default: return 5'd31;
		endcase
	endfunction

	task automatic test_directed();
		send_query(14'd1, 4'd1, 5'd1, 17'sd0, 1'b0, 17'd0);
		send_query(14'd1, 4'd1, 5'd1, -17'sd1, 1'b0, 17'd86399);
		send_query(14'd9999, 4'd12, 5'd31, 17'sd1, 1'b1, 17'h1FFFF);
		send_query(14'd9999, 4'd12, 5'd31, -17'sd65535, 1'b1, 17'd12345);
		send_query(14'd2000, 4'd2, 5'd29, 17'sd65535, 1'b0, 17'd1);
		send_query(14'd1900, 4'd2, 5'd29, 17'sd3, 1'b0, 17'd2);
		send_query(14'd2024, 4'd6, 5'd31, 17'sd3, 1'b0, 17'd3);
		send_query(14'd0, 4'd5, 5'd5, 17'sd3, 1'b0, 17'd4);
		send_query(14'h3FFF, 4'hF, 5'h1F, 17'sd3, 1'b1, 17'd5);
		send_query(14'd2024, 4'd0, 5'd1, 17'sd3, 1'b0, 17'd6);
		send_query(14'd2024, 4'd13, 5'd1, 17'sd3, 1'b0, 17'd7);
		send_query(14'd2024, 4'd3, 5'd0, 17'sd3, 1'b0, 17'd8);
		// weekend and weekday starts with zero, positive and negative weekday steps
		send_query(14'd2024, 4'd6, 5'd1, 17'sd0, 1'b1, 17'd9);
		send_query(14'd2024, 4'd6, 5'd1, 17'sd1, 1'b1, 17'd10);
		send_query(14'd2024, 4'd6, 5'd2, -17'sd1, 1'b1, 17'd11);
		send_query(14'd2024, 4'd6, 5'd7, 17'sd5, 1'b1, 17'd12);
		send_query(14'd2024, 4'd6, 5'd3, -17'sd5, 1'b1, 17'd13);
		send_query(14'd9999, 4'd12, 5'd31, 17'sd65535, 1'b0, 17'd14);
		send_query(14'd1, 4'd1, 5'd1, -17'sd65536, 1'b0, 17'd15);
		send_query(14'd1, 4'd1, 5'd1, 17'sd65535, 1'b1, 17'd16);
	endtask

	task automatic random_query(bit no_gap);
		logic [13:0] y;
		logic [3:0] m;
		logic [4:0] d;
		logic signed [OFFSET_BITS-1:0] offs;
		int sel;
		sel = $urandom_range(0, 19);
		y = (sel < 3) ? 14'($urandom_range(1, 300)) :
			(sel < 6) ? 14'($urandom_range(9700, 9999)) : 14'($urandom_range(1, 9999));
		m = 4'($urandom_range(1, 12));
		d = 5'($urandom_range(1, days_in(y, m)));
		if (sel == 19) begin
			y = 14'($urandom); m = 4'($urandom); d = 5'($urandom);
		end
		offs = ($urandom_range(0, 2) == 0) ? OFFSET_BITS'($urandom_range(0, 40) - 20)
			: OFFSET_BITS'($urandom);
		send_query(y, m, d, offs, 1'($urandom), 17'($urandom), no_gap);
	endtask

	task automatic test_random();
		repeat (1400) random_query(1'b0);
	endtask

	// hold the receiver off while offering back-to-back transactions
	task automatic test_backpressure();
		hold_off_cycles = 300;
		repeat (40) random_query(1'b1);
	endtask

	// accept results with random stalls and compare against predictions
	initial begin
		int stall;
		date_result_t want;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_stall_rand ? $urandom_range(0, 15) : 0;
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0 || hold_off_cycles > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_off_cycles > 0) begin
					@(posedge clk);
					hold_off_cycles--;
				end
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			if (expected_dates.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result transaction");
			end else begin
				want = expected_dates.pop_front();
				if (rsp.result_year !== want.year || rsp.result_month !== want.month ||
					rsp.result_day !== want.day || rsp.result_seconds !== want.secs ||
					rsp.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %0d-%0d-%0d s%0d st%0d got %0d-%0d-%0d s%0d st%0d",
							want.year, want.month, want.day, want.secs, want.status,
							rsp.result_year, rsp.result_month, rsp.result_day,
							rsp.result_seconds, rsp.status);
				end
			end
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		req.valid <= 1'b0;
		req.start_year <= '0; req.start_month <= '0; req.start_day <= '0;
		req.day_offset <= '0; req.weekdays_only <= 1'b0; req.start_seconds <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		req.valid <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_dates.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
